// File: design/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg: shared types and constants for the bottom-up merge sorter
// Key and tolerance widths, the command that passes from the front end to the
// sort engine, the engine states and status, and the key order test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

    // Key and tolerance widths
    localparam int KEY_W = 32;
    localparam int TOL_W = 16;

    // Command queue between the front end and the sort engine
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One classified input request
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             store;   // key fits and goes to the buffer
        logic             last;    // key closes the list
        logic             ovf;     // a key of this list was dropped so far
    } bms_cmd_t;

    // Sort engine states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RUN,
        ST_FETCH,
        ST_MERGE,
        ST_OUT_RD,
        ST_OUT_LD
    } bms_state_t;

    // Sort engine status seen by the top level
    typedef struct packed {
        logic loading;
        logic sorting;
        logic emitting;
    } bms_status_t;

    // Left key goes first unless it exceeds the right key by more than tol
    function automatic logic bms_take_left(
        input logic signed [KEY_W-1:0] a,
        input logic signed [KEY_W-1:0] b,
        input logic        [TOL_W-1:0] tol
    );
        logic signed [KEY_W:0] diff;
        diff = {a[KEY_W-1], a} - {b[KEY_W-1], b};
        return (a <= b) || (!diff[KEY_W] && (diff[KEY_W-1:0] <= KEY_W'(tol)));
    endfunction

endpackage

`default_nettype wire

// File: design/bms_ram.sv
// ----------------------------------------------------------------------------
// bms_ram: generic RAM, one write port, two registered read ports
// Write at one address and read at two addresses each cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and register both reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

`default_nettype wire

// File: design/bms_front.sv
// ----------------------------------------------------------------------------
// bms_front: input front end
// Accepts keys, counts the list, marks keys beyond capacity as dropped and
// pushes one command per request into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bms_front #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [bms_pkg::KEY_W-1:0]  s_key,
    input  wire logic                              s_last_key,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output bms_pkg::bms_cmd_t                      q_cmd
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          fits;

    // Classify the request
    always_comb begin
        s_ready      = !q_full;
        q_push       = s_valid && !q_full;
        fits         = (count_reg < CW'(MAX_ITEMS));
        q_cmd.key    = s_key;
        q_cmd.store  = fits;
        q_cmd.last   = s_last_key;
        q_cmd.ovf    = ovf_reg || !fits;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        if (q_push) begin
            if (s_last_key) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                count_next = fits ? count_reg + 1'b1 : count_reg;
                ovf_next   = ovf_reg || !fits;
            end
        end
    end

    // Hold the list count and drop flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// File: design/bms_queue.sv
// ----------------------------------------------------------------------------
// bms_queue: command queue
// Short first-in first-out queue between the front end and the sort engine;
// push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bms_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire bms_pkg::bms_cmd_t push_cmd,
    input  wire logic              pop,
    output bms_pkg::bms_cmd_t      head_cmd,
    output logic                   full,
    output logic                   empty
);

    bms_pkg::bms_cmd_t             mem_reg [bms_pkg::QDEPTH];
    logic [bms_pkg::QAW-1:0]       wr_ptr_reg;
    logic [bms_pkg::QAW-1:0]       rd_ptr_reg;
    logic [bms_pkg::QCW-1:0]       count_reg;
    logic                          do_push;
    logic                          do_pop;

    always_comb begin
        full     = (count_reg == bms_pkg::QCW'(bms_pkg::QDEPTH));
        empty    = (count_reg == '0);
        do_push  = push && !full;
        do_pop   = pop && !empty;
        head_cmd = mem_reg[rd_ptr_reg];
    end

    // Store pushed requests
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/bms_back.sv
// ----------------------------------------------------------------------------
// bms_back: sort engine
// Writes queued keys into buffer A, runs the bottom-up merge passes between
// buffers A and B, then streams the sorted list through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bms_back #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [bms_pkg::TOL_W-1:0]         tolerance,
    input  wire bms_pkg::bms_cmd_t                 q_cmd,
    input  wire logic                              q_empty,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [bms_pkg::KEY_W-1:0]       m_sorted_key,
    output logic                                   m_last_sorted,
    output logic                                   m_overflow,
    output bms_pkg::bms_status_t                   status
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int RW = CW + 2;

    bms_pkg::bms_state_t        state_reg, state_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW:0]                width_reg, width_next;
    logic [CW-1:0]              i_reg, i_next;
    logic [CW-1:0]              j_reg, j_next;
    logic [CW-1:0]              k_reg, k_next;
    logic [CW-1:0]              mid_reg, mid_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic                       swap_reg, swap_next;
    logic                       ovf_reg, ovf_next;
    logic                       m_valid_reg, m_valid_next;
    logic [bms_pkg::KEY_W-1:0]  m_key_reg, m_key_next;
    logic                       m_last_reg, m_last_next;
    logic                       m_ovf_reg, m_ovf_next;

    // Buffer ports
    logic                       a_we, b_we;
    logic [AW-1:0]              a_waddr;
    logic [bms_pkg::KEY_W-1:0]  a_wdata;
    logic [AW-1:0]              raddr0, raddr1;
    logic [bms_pkg::KEY_W-1:0]  a_rd0, a_rd1, b_rd0, b_rd1;
    logic [bms_pkg::KEY_W-1:0]  src_rd0, src_rd1;

    // Merge arithmetic
    logic [RW-1:0]              n_x, lo_x, w_x, lo_w, lo_2w, mid_x, hi_x;
    logic                       left_ok, right_ok, pick_left;
    logic [bms_pkg::KEY_W-1:0]  merge_key;
    logic                       run_done;
    logic                       out_free;
    logic                       out_last;

    bms_ram #(
        .WIDTH (bms_pkg::KEY_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf_a (
        .aclk    (aclk),
        .we      (a_we),
        .waddr   (a_waddr),
        .wdata   (a_wdata),
        .raddr_a (raddr0),
        .raddr_b (raddr1),
        .rdata_a (a_rd0),
        .rdata_b (a_rd1)
    );

    bms_ram #(
        .WIDTH (bms_pkg::KEY_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf_b (
        .aclk    (aclk),
        .we      (b_we),
        .waddr   (k_reg[AW-1:0]),
        .wdata   (merge_key),
        .raddr_a (raddr0),
        .raddr_b (raddr1),
        .rdata_a (b_rd0),
        .rdata_b (b_rd1)
    );

    // Source buffer select and merge decision
    always_comb begin
        src_rd0   = swap_reg ? b_rd0 : a_rd0;
        src_rd1   = swap_reg ? b_rd1 : a_rd1;
        left_ok   = (i_reg < mid_reg);
        right_ok  = (j_reg < hi_reg);
        pick_left = left_ok &&
                    (!right_ok || bms_pkg::bms_take_left(src_rd0, src_rd1, tolerance));
        merge_key = pick_left ? src_rd0 : src_rd1;
        run_done  = (CW'(k_reg + 1'b1) == hi_reg);
        out_free  = !m_valid_reg || m_ready;
        out_last  = (CW'(k_reg + 1'b1) == cnt_reg);
        n_x       = RW'(cnt_reg);
        lo_x      = RW'(lo_reg);
        w_x       = RW'(width_reg);
        lo_w      = lo_x + w_x;
        lo_2w     = lo_x + (w_x << 1);
        mid_x     = (lo_w < n_x) ? lo_w : n_x;
        hi_x      = (lo_2w < n_x) ? lo_2w : n_x;
    end

    // Next state, buffer access and output register
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        lo_next      = lo_reg;
        width_next   = width_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        swap_next    = swap_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_key_next   = m_key_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        q_pop        = 1'b0;
        a_we         = 1'b0;
        b_we         = 1'b0;
        a_waddr      = k_reg[AW-1:0];
        a_wdata      = merge_key;
        raddr0       = i_reg[AW-1:0];
        raddr1       = j_reg[AW-1:0];

        unique case (state_reg)
            // Take queued keys into buffer A
            bms_pkg::ST_LOAD: begin
                q_pop = !q_empty;
                if (!q_empty) begin
                    if (q_cmd.store) begin
                        a_we     = 1'b1;
                        a_waddr  = cnt_reg[AW-1:0];
                        a_wdata  = q_cmd.key;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (q_cmd.last) begin
                        ovf_next   = q_cmd.ovf;
                        lo_next    = '0;
                        width_next = (CW+1)'(1);
                        swap_next  = 1'b0;
                        state_next = bms_pkg::ST_RUN;
                    end
                end
            end
            // Set up the next run, or finish when one run covers the list
            bms_pkg::ST_RUN: begin
                if (w_x >= n_x) begin
                    k_next     = '0;
                    state_next = bms_pkg::ST_OUT_RD;
                end else begin
                    mid_next   = mid_x[CW-1:0];
                    hi_next    = hi_x[CW-1:0];
                    i_next     = lo_reg;
                    j_next     = mid_x[CW-1:0];
                    k_next     = lo_reg;
                    state_next = bms_pkg::ST_FETCH;
                end
            end
            // Wait for the run heads to be read
            bms_pkg::ST_FETCH: begin
                state_next = bms_pkg::ST_MERGE;
            end
            // Move one key to the destination buffer
            bms_pkg::ST_MERGE: begin
                a_we = swap_reg;
                b_we = !swap_reg;
                if (pick_left) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (run_done) begin
                    if (lo_2w >= n_x) begin
                        lo_next    = '0;
                        width_next = {width_reg[CW-1:0], 1'b0};
                        swap_next  = !swap_reg;
                    end else begin
                        lo_next = lo_2w[CW-1:0];
                    end
                    state_next = bms_pkg::ST_RUN;
                end else begin
                    state_next = bms_pkg::ST_FETCH;
                end
            end
            // Read the next sorted key
            bms_pkg::ST_OUT_RD: begin
                raddr0     = k_reg[AW-1:0];
                state_next = bms_pkg::ST_OUT_LD;
            end
            // Hand the key to the output register once it is free
            bms_pkg::ST_OUT_LD: begin
                raddr0 = k_reg[AW-1:0];
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_key_next   = src_rd0;
                    m_last_next  = out_last;
                    m_ovf_next   = ovf_reg;
                    if (out_last) begin
                        cnt_next   = '0;
                        state_next = bms_pkg::ST_LOAD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = bms_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = bms_pkg::ST_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bms_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Counters and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            lo_reg      <= '0;
            width_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            swap_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            lo_reg      <= lo_next;
            width_reg   <= width_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            swap_reg    <= swap_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_key_reg  <= m_key_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    always_comb begin
        m_valid         = m_valid_reg;
        m_sorted_key    = m_key_reg;
        m_last_sorted   = m_last_reg;
        m_overflow      = m_ovf_reg;
        status.loading  = (state_reg == bms_pkg::ST_LOAD);
        status.sorting  = (state_reg == bms_pkg::ST_RUN) ||
                          (state_reg == bms_pkg::ST_FETCH) ||
                          (state_reg == bms_pkg::ST_MERGE);
        status.emitting = (state_reg == bms_pkg::ST_OUT_RD) ||
                          (state_reg == bms_pkg::ST_OUT_LD);
    end

endmodule

`default_nettype wire

// File: design/bottom_up_merge_sorter.sv
// ----------------------------------------------------------------------------
// bottom_up_merge_sorter: key list sorter, bottom-up merge sort
// Collects a list of signed Q16.16 keys, sorts it ascending with a tolerance
// on ties, and streams the sorted list out.
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload
//   s_        s_valid / s_ready   s_key, s_last_key
//   m_        m_valid / m_ready   m_sorted_key, m_last_sorted, m_overflow
//   cfg_      cfg_we              cfg_wdata (equal tolerance)
//
// Keys load at one per cycle through a four-entry command queue. A list of n
// keys then takes ceil(log2(n)) merge passes, with a setup state per run
// and each key costing a read state and a compare/write state on the buffers;
// on output each key is read, then moved into the output register when free.
// While a list is sorted or emitted the queue fills and s_ready drops.
// Reset is synchronous, active low; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module bottom_up_merge_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [bms_pkg::KEY_W-1:0]  s_key,
    input  wire logic                              s_last_key,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [bms_pkg::KEY_W-1:0]       m_sorted_key,
    output logic                                   m_last_sorted,
    output logic                                   m_overflow,
    input  wire logic                              cfg_we,
    input  wire logic [bms_pkg::TOL_W-1:0]         cfg_wdata
);

    logic [bms_pkg::TOL_W-1:0] tol_reg;
    logic                      q_push, q_pop, q_full, q_empty;
    bms_pkg::bms_cmd_t         push_cmd, head_cmd;
    bms_pkg::bms_status_t      status;

    // Hold the equal tolerance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    bms_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_key      (s_key),
        .s_last_key (s_last_key),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    bms_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    bms_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tolerance     (tol_reg),
        .q_cmd         (head_cmd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_key  (m_sorted_key),
        .m_last_sorted (m_last_sorted),
        .m_overflow    (m_overflow),
        .status        (status)
    );

`ifndef SYNTHESIS
    // The engine pops only while loading, and never from an empty queue
    a_pop_when_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (status.loading && !q_empty))
        else $error("queue popped outside load phase or while empty");

    // A new result appears only from the output phase
    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(status.emitting))
        else $error("result raised outside output phase");

    // A full queue cannot drain while the sort engine is busy
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_full && !status.loading) |=> !(q_empty))
        else $error("queue drained while engine busy");
`endif

endmodule

`default_nettype wire
